@@ sv/ard_pkg.sv @@
// Shared types, register indexes and fixed-point constants of the rep detector.
`default_nettype none
package ard_pkg;

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
        logic [31:0]        time_ms;
    } t_in;

    typedef struct packed {
        logic        is_moving;
        logic        rep_done;
        logic [15:0] rep_peak;
        logic [31:0] rep_total;
        logic [31:0] rep_length_ms;
    } t_out;

    typedef enum logic [2:0] {
        REG_GRAV_X   = 3'd0,
        REG_GRAV_Y   = 3'd1,
        REG_GRAV_Z   = 3'd2,
        REG_INV_MAG  = 3'd3,
        REG_MIN_PEAK = 3'd4,
        REG_MAX_PEAK = 3'd5,
        REG_MAX_REP  = 3'd6,
        REG_HOLD     = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LANE,
        ST_DOT,
        ST_VERT,
        ST_SCALE,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // Squared magnitude window, compared as m2*DEN against HI^2 and LO^2
    localparam logic [19:0] MAG_DEN   = 20'd962361;
    localparam logic [45:0] MAG_HI_SQ = 46'd17833526296576;
    localparam logic [45:0] MAG_LO_SQ = 46'd14541836517376;
    localparam logic [9:0]  TIMEOUT_EXTRA_MS = 10'd500;
    // Vertical scale: floor(p*981/160000) as (p*MUL)>>SHIFT, exact for p<2^31
    localparam logic [40:0] VERT_MUL   = 41'd1725793450958;
    localparam int          VERT_SHIFT = 48;

endpackage
`default_nettype wire

@@ sv/accel_rep_detector_unit.sv @@
// Top level: three axis lanes, a merging projection datapath and the rep state machine.
`default_nettype none
// Each sample request passes through the three parallel axis lanes, then the
// gravity dot product, the inverse-magnitude scaling, the m/s conversion and the
// rep decision, each registered, and then an output step that marks the result
// valid. The priming sample skips the datapath and goes from the lane step
// straight to the output step. A new sample is taken only in the idle step with
// the result register empty, so a new sample is not accepted until the previous
// result has been taken on the output side. Configuration writes are taken at any
// time and must only be issued while no sample is in flight.
module accel_rep_detector_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  wire ard_pkg::t_in i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output ard_pkg::t_out   o_out_data,
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire [2:0]       i_cfg_index,
    input  wire [23:0]      i_cfg_data
);
    localparam int VW = FRAC_BITS + 32;

    ard_pkg::t_state r_state, n_state;
    ard_pkg::t_in    r_in;
    logic signed [15:0] r_gx, r_gy, r_gz;
    logic [23:0] r_inv;
    logic [15:0] r_minp, r_maxp, r_maxrep, r_hold;

    logic r_primed, r_moving, r_armed;
    logic [31:0] r_still_start, r_rep_begin, r_valid_reps;
    logic [15:0] r_peak;
    logic        r_active;
    logic [49:0] r_dot_abs;
    logic [63:0] r_p;
    logic [15:0] r_vert;
    logic        r_out_valid;
    ard_pkg::t_out r_out;

    logic lane_step, lane_clear, lane_prime;
    logic signed [VW-1:0] sp_x, sp_y, sp_z;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx <= '0; r_gy <= '0; r_gz <= 16'sd4096; r_inv <= 24'd4096;
            r_minp <= 16'd20; r_maxp <= 16'd768; r_maxrep <= 16'd2500; r_hold <= 16'd200;
        end else if (i_cfg_valid) begin
            unique case (ard_pkg::t_reg'(i_cfg_index))
                ard_pkg::REG_GRAV_X:   r_gx     <= i_cfg_data[15:0];
                ard_pkg::REG_GRAV_Y:   r_gy     <= i_cfg_data[15:0];
                ard_pkg::REG_GRAV_Z:   r_gz     <= i_cfg_data[15:0];
                ard_pkg::REG_INV_MAG:  r_inv    <= i_cfg_data;
                ard_pkg::REG_MIN_PEAK: r_minp   <= i_cfg_data[15:0];
                ard_pkg::REG_MAX_PEAK: r_maxp   <= i_cfg_data[15:0];
                ard_pkg::REG_MAX_REP:  r_maxrep <= i_cfg_data[15:0];
                ard_pkg::REG_HOLD:     r_hold   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == ard_pkg::ST_IDLE) && !r_out_valid;
    assign lane_prime = (r_state == ard_pkg::ST_LANE) && !r_primed;
    assign lane_step  = (r_state == ard_pkg::ST_LANE) && r_primed;

    ard_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_prime(lane_prime), .i_step(lane_step),
        .i_clear(lane_clear), .i_sample(r_in.sample_x), .i_grav(r_gx),
        .o_speed(sp_x));
    ard_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_prime(lane_prime), .i_step(lane_step),
        .i_clear(lane_clear), .i_sample(r_in.sample_y), .i_grav(r_gy),
        .o_speed(sp_y));
    ard_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_prime(lane_prime), .i_step(lane_step),
        .i_clear(lane_clear), .i_sample(r_in.sample_z), .i_grav(r_gz),
        .o_speed(sp_z));

    // Merge: dot product of integer speeds with gravity
    logic signed [31:0] ix, iy, iz;
    logic signed [49:0] dot;
    assign ix  = 32'(sp_x >>> FRAC_BITS);
    assign iy  = 32'(sp_y >>> FRAC_BITS);
    assign iz  = 32'(sp_z >>> FRAC_BITS);
    assign dot = 50'(ix * r_gx) + 50'(iy * r_gy) + 50'(iz * r_gz);

    // Magnitude window test on the raw sample
    logic signed [33:0] m2;
    logic [53:0] m2d;
    assign m2  = 34'(r_in.sample_x * r_in.sample_x) + 34'(r_in.sample_y * r_in.sample_y)
               + 34'(r_in.sample_z * r_in.sample_z);
    assign m2d = 54'(m2[32:0]) * 54'(ard_pkg::MAG_DEN);

    logic [31:0] dur, still_el;
    logic [32:0] tmo;
    assign dur      = r_in.time_ms - r_rep_begin;
    assign still_el = r_in.time_ms - r_still_start;
    assign tmo      = 33'(r_maxrep) + 33'(ard_pkg::TIMEOUT_EXTRA_MS);

    // Scale to Q8.8 m/s by reciprocal multiplication; anything from 2^24 up saturates
    logic [64:0] q_full;
    logic [16:0] q;
    assign q_full = 65'(r_p[23:0]) * 65'(ard_pkg::VERT_MUL);
    assign q      = 17'(q_full >> ard_pkg::VERT_SHIFT);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ard_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ard_pkg::ST_IDLE:   if (i_in_valid && o_in_ready) n_state = ard_pkg::ST_LANE;
            ard_pkg::ST_LANE:   n_state = r_primed ? ard_pkg::ST_DOT : ard_pkg::ST_OUT;
            ard_pkg::ST_DOT:    n_state = ard_pkg::ST_VERT;
            ard_pkg::ST_VERT:   n_state = ard_pkg::ST_SCALE;
            ard_pkg::ST_SCALE:  n_state = ard_pkg::ST_DECIDE;
            ard_pkg::ST_DECIDE: n_state = ard_pkg::ST_OUT;
            ard_pkg::ST_OUT:    n_state = ard_pkg::ST_IDLE;
            default:            n_state = ard_pkg::ST_IDLE;
        endcase
    end

    // Rep decision, computed combinationally in the decide step
    logic d_moving, d_armed, d_done, d_clear;
    logic [31:0] d_begin, d_still;
    logic [15:0] d_peak;
    always_comb begin
        d_moving = r_moving; d_armed = r_armed; d_done = 1'b0; d_clear = 1'b0;
        d_begin = r_rep_begin; d_still = r_still_start; d_peak = r_peak;
        if (!r_moving) begin
            d_clear = 1'b1;
            if (r_active) begin
                d_moving = 1'b1; d_armed = 1'b0; d_begin = r_in.time_ms; d_peak = '0;
            end
        end else begin
            if (r_vert > r_peak) d_peak = r_vert;
            if (!r_active) begin
                if (!r_armed) begin
                    d_armed = 1'b1; d_still = r_in.time_ms;
                end else if (still_el >= 32'(r_hold)) begin
                    if (d_peak >= r_minp && d_peak <= r_maxp && dur <= 32'(r_maxrep))
                        d_done = 1'b1;
                    d_moving = 1'b0; d_armed = 1'b0; d_clear = 1'b1;
                end
            end else begin
                d_armed = 1'b0;
            end
            if (d_moving && 33'(dur) > tmo) begin
                d_moving = 1'b0; d_armed = 1'b0; d_clear = 1'b1;
            end
        end
    end
    assign lane_clear = (r_state == ard_pkg::ST_DECIDE) && d_clear;

    // Datapath and rep state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0; r_moving <= 1'b0; r_armed <= 1'b0;
            r_still_start <= '0; r_rep_begin <= '0; r_peak <= '0; r_valid_reps <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ard_pkg::ST_IDLE: if (i_in_valid && o_in_ready) r_in <= i_in_data;
                ard_pkg::ST_LANE: begin
                    r_active <= (m2d > 54'(ard_pkg::MAG_HI_SQ))
                             || (m2d < 54'(ard_pkg::MAG_LO_SQ));
                    if (!r_primed) begin
                        r_primed <= 1'b1;
                        r_out <= '{is_moving: 1'b0, rep_done: 1'b0, rep_peak: '0,
                                   rep_total: r_valid_reps, rep_length_ms: '0};
                    end
                end
                ard_pkg::ST_DOT:   r_dot_abs <= dot[49] ? 50'(-dot) : dot;
                ard_pkg::ST_VERT:  r_p <= (64'(r_dot_abs >> 12) * 64'(r_inv)) >> 12;
                ard_pkg::ST_SCALE: r_vert <= ((r_p[63:24] != '0) || q[16]) ? 16'hFFFF : q[15:0];
                ard_pkg::ST_DECIDE: begin
                    r_moving <= d_moving; r_armed <= d_armed; r_rep_begin <= d_begin;
                    r_still_start <= d_still; r_peak <= d_peak;
                    if (d_done) r_valid_reps <= r_valid_reps + 32'd1;
                    r_out.is_moving <= d_moving;
                    r_out.rep_done  <= d_done;
                    r_out.rep_total <= r_valid_reps + 32'(d_done);
                    r_out.rep_peak  <= (d_moving || d_done) ? d_peak : '0;
                    r_out.rep_length_ms <= (d_moving || d_done) ? r_in.time_ms - d_begin : '0;
                end
                ard_pkg::ST_OUT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

@@ sv/ard_lane.sv @@
// One axis lane: exponential smoothing, gravity removal and speed integration.
`default_nettype none
module ard_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_prime,
    input  wire                          i_step,
    input  wire                          i_clear,
    input  wire signed [15:0]            i_sample,
    input  wire signed [15:0]            i_grav,
    output logic signed [FRAC_BITS+31:0] o_speed
);
    localparam int SW = FRAC_BITS + 16;
    localparam int VW = FRAC_BITS + 32;
    localparam logic [FRAC_BITS-1:0] ALPHA =
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    logic signed [SW-1:0] r_smooth;
    logic signed [VW-1:0] r_speed;
    logic signed [SW:0]   diff;
    logic signed [SW+FRAC_BITS+1:0] prod;
    logic signed [SW-1:0] n_smooth;
    logic signed [VW+1:0] sum;
    logic signed [VW-1:0] n_speed;
    logic signed [SW-1:0] sample_q;
    logic signed [SW:0]   net;

    assign sample_q = {i_sample, {FRAC_BITS{1'b0}}};
    assign diff     = (SW+1)'(sample_q) - (SW+1)'(r_smooth);
    assign prod     = (SW+FRAC_BITS+2)'(diff) * $signed({1'b0, ALPHA});
    assign n_smooth = r_smooth + SW'(prod >>> FRAC_BITS);
    assign net      = (SW+1)'(n_smooth) - (SW+1)'($signed({i_grav, {FRAC_BITS{1'b0}}}));
    assign sum      = (VW+2)'(r_speed) + (VW+2)'(net);

    // Saturate the integrated speed
    always_comb begin
        if (!sum[VW+1] && (sum[VW+1:VW-1] != 3'b000)) begin
            n_speed = {1'b0, {(VW-1){1'b1}}};
        end else if (sum[VW+1] && (sum[VW+1:VW-1] != 3'b111)) begin
            n_speed = {1'b1, {(VW-1){1'b0}}};
        end else begin
            n_speed = sum[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_prime) begin
            r_smooth <= sample_q;
        end else if (i_step) begin
            r_smooth <= n_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_speed <= '0;
        end else if (i_step) begin
            r_speed <= n_speed;
        end
    end

    assign o_speed  = r_speed;
endmodule
`default_nettype wire

@@ sv/ard_checker.sv @@
// Port-level checker for the rep detector, bound to the top level.
`default_nettype none
module ard_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_ready,
    input wire            o_out_valid,
    input wire            i_out_ready,
    input wire ard_pkg::t_out o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request taken while result pending");
    a_done_implies_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rep_done |-> !o_out_data.is_moving)
        else $error("completed rep still moving");
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request in flight");
endmodule

bind accel_rep_detector_unit ard_checker u_ard_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data));
`default_nettype wire
